[rtl/ubrh_pkg.sv]
// shared constants, command codes and memory request type for the undo/redo history
package ubrh_pkg;

  localparam int DEPTH     = 64;
  localparam int SNAP_BITS = 64;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMD_W     = 2;
  localparam int SNAPSHOT_W = 64;
  localparam int ENTRIES_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_UNDO  = 2'd1,
    CMD_REDO  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [PTR_W-1:0]     addr;
    logic [SNAP_BITS-1:0] wdata;
  } mem_req_t;

endpackage

[rtl/ubrh_ram.sv]
// generic single-port synchronous ram with registered read
module ubrh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/ubrh_ctrl.sv]
// cursor and ring pointer control, memory requests and result register
module ubrh_ctrl (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [ubrh_pkg::CMD_W-1:0]             command,
  input  logic [ubrh_pkg::SNAPSHOT_W-1:0]        snapshot,
  output ubrh_pkg::mem_req_t                     mem_req,
  input  logic [ubrh_pkg::SNAP_BITS-1:0]         mem_rdata,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   ok,
  output logic [ubrh_pkg::SNAPSHOT_W-1:0]        restored,
  output logic [ubrh_pkg::ENTRIES_W-1:0]         entries
);
  import ubrh_pkg::*;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t           state;
  logic [PTR_W-1:0] oldest;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] cursor;

  logic             accept;
  cmd_t             cmd;
  logic [CNT_W-1:0] push_pos;
  logic [CNT_W-1:0] push_cnt;
  logic             push_evict;
  logic [PTR_W-1:0] oldest_inc;
  logic [PTR_W-1:0] cursor_dec;
  logic [PTR_W-1:0] cursor_inc;
  logic             undo_ok;
  logic             redo_ok;
  logic [PTR_W-1:0] slot_off;
  logic [PTR_W:0]   slot_sum;
  logic [PTR_W-1:0] slot;

  logic [PTR_W-1:0] oldest_next;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] cursor_next;
  logic             ok_next;
  logic             read_go;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign cmd      = cmd_t'(command);

  // position of the new entry counted from the oldest one
  assign push_pos   = (count != '0) ? (CNT_W'(cursor) + CNT_W'(1)) : '0;
  assign push_cnt   = push_pos + CNT_W'(1);
  assign push_evict = push_cnt > CNT_W'(DEPTH);
  assign oldest_inc = (oldest == PTR_W'(DEPTH - 1)) ? '0 : oldest + PTR_W'(1);
  assign cursor_dec = cursor - PTR_W'(1);
  assign cursor_inc = cursor + PTR_W'(1);
  assign undo_ok    = (count != '0) && (cursor != '0);
  assign redo_ok    = (count != '0) && ((CNT_W'(cursor) + CNT_W'(1)) < count);

  always_comb begin
    oldest_next = oldest;
    count_next  = count;
    cursor_next = cursor;
    ok_next     = 1'b0;
    read_go     = 1'b0;
    slot_off    = '0;
    unique case (cmd)
      CMD_PUSH: begin
        ok_next  = 1'b1;
        // a full history with the cursor on top wraps onto the evicted slot
        slot_off = (push_pos == CNT_W'(DEPTH)) ? '0 : push_pos[PTR_W-1:0];
        if (push_evict) begin
          oldest_next = oldest_inc;
          count_next  = CNT_W'(DEPTH);
          cursor_next = PTR_W'(DEPTH - 1);
        end else begin
          count_next  = push_cnt;
          cursor_next = push_pos[PTR_W-1:0];
        end
      end
      CMD_UNDO: begin
        ok_next  = undo_ok;
        read_go  = undo_ok;
        slot_off = cursor_dec;
        if (undo_ok) begin
          cursor_next = cursor_dec;
        end
      end
      CMD_REDO: begin
        ok_next  = redo_ok;
        read_go  = redo_ok;
        slot_off = cursor_inc;
        if (redo_ok) begin
          cursor_next = cursor_inc;
        end
      end
      CMD_CLEAR: begin
        ok_next     = 1'b1;
        oldest_next = '0;
        count_next  = '0;
        cursor_next = '0;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // ring slot = (oldest + offset) mod depth, sum stays below twice the depth
  assign slot_sum = {1'b0, oldest} + {1'b0, slot_off};
  assign slot     = (slot_sum >= (PTR_W + 1)'(DEPTH)) ?
                    PTR_W'(slot_sum - (PTR_W + 1)'(DEPTH)) : slot_sum[PTR_W-1:0];

  assign mem_req.en    = accept && ((cmd == CMD_PUSH) || read_go);
  assign mem_req.we    = (cmd == CMD_PUSH);
  assign mem_req.addr  = slot;
  assign mem_req.wdata = snapshot[SNAP_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      count     <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            oldest   <= oldest_next;
            count    <= count_next;
            cursor   <= cursor_next;
            ok       <= ok_next;
            entries  <= ENTRIES_W'(count_next);
            restored <= '0;
            if (read_go) begin
              // result waits for the ram read beat
              out_valid <= 1'b0;
              state     <= S_READ;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          restored  <= SNAPSHOT_W'(mem_rdata);
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/bounded_undo_redo_history_top.sv]
// top level of the bounded undo/redo history: control plus snapshot ram
// Keeps up to DEPTH (64) snapshots in a single-port synchronous ram used as a ring, with a
// cursor for undo and redo. Push, clear and a failed undo or redo give their result in the
// cycle after the input beat, and a new command is taken every cycle as long as the
// result register drains. A successful undo or redo first reads the ram into its output
// register and then loads the result register; in_ready is low during that read. The ram
// needs no clearing after reset: only slots inside the held history are ever read, and
// those were all written by a push.
module bounded_undo_redo_history_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ubrh_pkg::CMD_W-1:0]        command,
  input  logic [ubrh_pkg::SNAPSHOT_W-1:0]   snapshot,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              ok,
  output logic [ubrh_pkg::SNAPSHOT_W-1:0]   restored,
  output logic [ubrh_pkg::ENTRIES_W-1:0]    entries
);
  import ubrh_pkg::*;

  mem_req_t             mem_req;
  logic [SNAP_BITS-1:0] mem_rdata;

  ubrh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .snapshot  (snapshot),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .restored  (restored),
    .entries   (entries)
  );

  ubrh_ram #(
    .WIDTH (SNAP_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  a_entries_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entries <= ENTRIES_W'(DEPTH)))
    else $error("history holds more entries than its depth");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (restored == '0))
    else $error("failed command returned a snapshot");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (command == CMD_CLEAR)) |=>
      (out_valid && ok && (entries == '0)))
    else $error("clear did not empty the history");

  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (command == CMD_PUSH)) |=>
      (out_valid && ok && (entries != '0) && (restored == '0)))
    else $error("push result wrong");

endmodule

[dv/testbench.sv]
// self-checking testbench for the bounded undo/redo history top level
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ubrh_pkg::*;

  localparam int RAND_ITEMS = 880;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [SNAPSHOT_W-1:0] SNAP_MASK =
    (SNAP_BITS >= SNAPSHOT_W) ? '1 : ((64'd1 << SNAP_BITS) - 64'd1);

  typedef struct packed {
    logic                  ok;
    logic [SNAPSHOT_W-1:0] restored;
    logic [ENTRIES_W-1:0]  entries;
  } hist_result_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [SNAPSHOT_W-1:0] snap;
    logic                  typed;
    hist_result_t          res;
  } dir_row_t;

  // typed rows carry a result that follows directly from the command; the rest use the predictor
  localparam int DIR_ROWS_N = 23;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{CMD_UNDO,  64'hDEAD_BEEF_0BAD_F00D, 1'b1, '{1'b0, 64'd0, 7'd0}},
    '{CMD_REDO,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'd0, 7'd0}},
    '{CMD_CLEAR, 64'h0000_0000_0000_0000, 1'b1, '{1'b1, 64'd0, 7'd0}},
    '{CMD_PUSH,  64'h0000_0000_0000_0000, 1'b1, '{1'b1, 64'd0, 7'd1}},
    '{CMD_UNDO,  64'h0000_0000_0000_0000, 1'b1, '{1'b0, 64'd0, 7'd1}},
    '{CMD_REDO,  64'h0000_0000_0000_0000, 1'b1, '{1'b0, 64'd0, 7'd1}},
    '{CMD_PUSH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 64'd0, 7'd2}},
    '{CMD_UNDO,  64'h5555_5555_5555_5555, 1'b1, '{1'b1, 64'd0, 7'd2}},
    '{CMD_REDO,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 7'd2}},
    '{CMD_REDO,  64'h0000_0000_0000_0000, 1'b1, '{1'b0, 64'd0, 7'd2}},
    '{CMD_PUSH,  64'h8000_0000_0000_0001, 1'b1, '{1'b1, 64'd0, 7'd3}},
    '{CMD_PUSH,  64'h7FFF_FFFF_FFFF_FFFE, 1'b1, '{1'b1, 64'd0, 7'd4}},
    '{CMD_UNDO,  64'h0000_0000_0000_0000, 1'b0, '{1'b0, 64'd0, 7'd0}},
    '{CMD_UNDO,  64'h0000_0000_0000_0000, 1'b0, '{1'b0, 64'd0, 7'd0}},
    // push from the middle drops the newer entries
    '{CMD_PUSH,  64'h0123_4567_89AB_CDEF, 1'b0, '{1'b0, 64'd0, 7'd0}},
    '{CMD_REDO,  64'h0000_0000_0000_0000, 1'b0, '{1'b0, 64'd0, 7'd0}},
    '{CMD_UNDO,  64'h0000_0000_0000_0000, 1'b0, '{1'b0, 64'd0, 7'd0}},
    '{CMD_UNDO,  64'h0000_0000_0000_0000, 1'b0, '{1'b0, 64'd0, 7'd0}},
    '{CMD_UNDO,  64'h0000_0000_0000_0000, 1'b0, '{1'b0, 64'd0, 7'd0}},
    '{CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 64'd0, 7'd0}},
    '{CMD_REDO,  64'h0000_0000_0000_0000, 1'b1, '{1'b0, 64'd0, 7'd0}},
    '{CMD_PUSH,  64'hA5A5_A5A5_5A5A_5A5A, 1'b1, '{1'b1, 64'd0, 7'd1}},
    '{CMD_UNDO,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 64'd0, 7'd1}}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      command = CMD_PUSH;
  logic [SNAPSHOT_W-1:0] snapshot = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  ok;
  logic [SNAPSHOT_W-1:0] restored;
  logic [ENTRIES_W-1:0]  entries;

  logic                  typed_beat = 1'b0;
  hist_result_t          typed_result = '0;
  bit                    idle_en = 1'b1;

  // predictor state
  logic [SNAPSHOT_W-1:0] snap_ring [DEPTH];
  logic [PTR_W-1:0]      ring_oldest;
  logic [CNT_W-1:0]      ring_count;
  logic [PTR_W-1:0]      ring_cursor;

  hist_result_t          pending_results [$];
  int                    fail_count = 0;
  int                    stall_cycles = 0;
  int                    n_push = 0, n_hit = 0, n_miss = 0, n_clear = 0, n_evict = 0;
  int                    deepest = 0;

  bounded_undo_redo_history_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .snapshot  (snapshot),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .restored  (restored),
    .entries   (entries)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic hist_result_t step_history(input cmd_t cmd, input logic [SNAPSHOT_W-1:0] snap);
    hist_result_t r;
    int           held;
    r = '0;
    case (cmd)
      CMD_PUSH: begin
        held = (ring_count > 0) ? int'(ring_cursor) + 1 : 0;
        snap_ring[(int'(ring_oldest) + held) % DEPTH] = snap & SNAP_MASK;
        held++;
        if (held > DEPTH) begin
          ring_oldest = PTR_W'((int'(ring_oldest) + 1) % DEPTH);
          held--;
          n_evict++;
        end
        ring_count  = CNT_W'(held);
        ring_cursor = PTR_W'(held - 1);
        r.ok = 1'b1;
      end
      CMD_UNDO: begin
        if (ring_count > 0 && ring_cursor > 0) begin
          ring_cursor = ring_cursor - 1'b1;
          r.restored = snap_ring[(int'(ring_oldest) + int'(ring_cursor)) % DEPTH] & SNAP_MASK;
          r.ok = 1'b1;
        end
      end
      CMD_REDO: begin
        if (ring_count > 0 && int'(ring_cursor) + 1 < int'(ring_count)) begin
          ring_cursor = ring_cursor + 1'b1;
          r.restored = snap_ring[(int'(ring_oldest) + int'(ring_cursor)) % DEPTH] & SNAP_MASK;
          r.ok = 1'b1;
        end
      end
      default: begin
        ring_oldest = '0;
        ring_count  = '0;
        ring_cursor = '0;
        r.ok = 1'b1;
      end
    endcase
    r.entries = ENTRIES_W'(ring_count);
    return r;
  endfunction

  // input beats feed the predictor, output beats are checked against the oldest expectation
  always @(posedge clk) begin
    hist_result_t want;
    hist_result_t pred;
    if (rst) begin
      ring_oldest  <= '0;
      ring_count   <= '0;
      ring_cursor  <= '0;
      stall_cycles <= 0;
    end else begin
      if (in_valid && in_ready) begin
        pred = step_history(cmd_t'(command), snapshot);
        case (cmd_t'(command))
          CMD_PUSH:  n_push++;
          CMD_CLEAR: n_clear++;
          default:   if (pred.ok) n_hit++; else n_miss++;
        endcase
        if (int'(ring_count) > deepest) deepest = int'(ring_count);
        pending_results.push_back(typed_beat ? typed_result : pred);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: ok %0d restored %h entries %0d",
                 ok, restored, entries);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (ok !== want.ok) begin
            $error("ok: expected %0d actual %0d", want.ok, ok);
            fail_count++;
          end
          if (restored !== want.restored) begin
            $error("restored: expected %h actual %h", want.restored, restored);
            fail_count++;
          end
          if (entries !== want.entries) begin
            $error("entries: expected %0d actual %0d", want.entries, entries);
            fail_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= idle_en ? ($urandom_range(0, 99) >= 16) : 1'b1;
    end
  end

  task automatic send_command(input cmd_t cmd, input logic [SNAPSHOT_W-1:0] snap,
                              input logic typed, input hist_result_t res);
    while (idle_en && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    snapshot     <= snap;
    typed_beat   <= typed;
    typed_result <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender off until every outstanding result has been seen
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [SNAPSHOT_W-1:0] pick_snapshot();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, SNAPSHOT_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int   rand_sent;
    int   burst_kind;
    int   burst_len;
    int   roll;
    cmd_t cmd;
    rand_sent = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      send_command(DIR_ROWS[i].cmd, DIR_ROWS[i].snap, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end
    wait_results_drained();

    // overfill to force eviction and wrap, then walk the cursor to both ends and past them
    repeat (DEPTH + 8) begin
      send_command(CMD_PUSH, pick_snapshot(), 1'b0, '0);
      rand_sent++;
    end
    repeat (DEPTH + 2) begin
      send_command(CMD_UNDO, pick_snapshot(), 1'b0, '0);
      rand_sent++;
    end
    repeat (DEPTH + 2) begin
      send_command(CMD_REDO, pick_snapshot(), 1'b0, '0);
      rand_sent++;
    end
    wait_results_drained();

    while (rand_sent < RAND_ITEMS) begin
      burst_kind = $urandom_range(0, 9);
      burst_len  = (burst_kind < 8) ? $urandom_range(10, 80) : $urandom_range(5, 20);
      repeat (burst_len) begin
        idle_en = !(rand_sent >= 400 && rand_sent < 580);
        roll = $urandom_range(0, 99);
        if (burst_kind < 4) begin
          cmd = (roll < 80) ? CMD_PUSH : ((roll < 90) ? CMD_UNDO : CMD_REDO);
        end else if (burst_kind < 8) begin
          cmd = (roll < 45) ? CMD_UNDO : ((roll < 90) ? CMD_REDO : CMD_PUSH);
        end else begin
          cmd = cmd_t'($urandom_range(0, 3));
        end
        send_command(cmd, pick_snapshot(), 1'b0, '0);
        rand_sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_results_drained();
    end
    idle_en = 1'b1;
    in_valid <= 1'b0;
    @(negedge clk);

    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("ran %0d commands: %0d pushes (%0d evictions), %0d clears, %0d undo/redo moves",
             n_push + n_clear + n_hit + n_miss, n_push, n_evict, n_clear, n_hit);
    $display("%0d undo/redo refused at the ends, deepest history %0d entries", n_miss, deepest);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
